>>> hw/rtl/rpip_pkg.sv
// ----------------------------------------------------------------------------
// rpip_pkg
// Types and character constants shared by the radix-prefixed integer parser.
// ----------------------------------------------------------------------------
package rpip_pkg;

    localparam int OUT_W  = 64;
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_PERIOD   = 8'h2E;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_F  = 8'h46;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_F  = 8'h66;
    localparam logic [7:0] CH_LOWER_B  = 8'h62;
    localparam logic [7:0] CH_LOWER_X  = 8'h78;
    localparam logic [7:0] DIGIT_MASK  = 8'h0F;
    localparam logic [7:0] LETTER_MASK = 8'h1F;
    localparam logic [7:0] LETTER_BASE = 8'd9;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FRACTION = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_BIN = 2'd1,
        RADIX_OCT = 2'd2,
        RADIX_HEX = 2'd3
    } t_radix;

    typedef enum logic [3:0] {
        PH_START = 4'b0001,
        PH_MINUS = 4'b0010,
        PH_ZERO  = 4'b0100,
        PH_BODY  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [3:0] digit;
        logic       is_digit;
        logic       is_minus;
        logic       is_period;
        logic       is_zero;
        logic       is_b;
        logic       is_x;
        logic       last;
    } t_char_class;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

>>> hw/rtl/rpip_front.sv
// ----------------------------------------------------------------------------
// rpip_front
// Classifies each incoming character and queues it for the token engine.
// ----------------------------------------------------------------------------
module rpip_front
    import rpip_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_code,
    input  logic        i_last_char,
    output t_char_class o_head,
    output t_q_stat     o_q,
    input  logic        i_pop
);

    t_char_class              w_cls;
    t_char_class              r_mem [QDEPTH];
    logic [QPTR_W-1:0]        r_wr_ptr;
    logic [QPTR_W-1:0]        r_rd_ptr;
    logic [QCNT_W-1:0]        r_count;
    logic                     w_push;
    logic                     w_dec;
    logic                     w_upper;
    logic                     w_lower;

    always_comb begin
        w_dec   = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
        w_upper = (i_char_code >= CH_UPPER_A) && (i_char_code <= CH_UPPER_F);
        w_lower = (i_char_code >= CH_LOWER_A) && (i_char_code <= CH_LOWER_F);
        w_cls.is_digit  = w_dec || w_upper || w_lower;
        if (w_dec) begin
            w_cls.digit = 4'(i_char_code & DIGIT_MASK);
        end else begin
            w_cls.digit = 4'(LETTER_BASE + (i_char_code & LETTER_MASK));
        end
        w_cls.is_minus  = (i_char_code == CH_MINUS);
        w_cls.is_period = (i_char_code == CH_PERIOD);
        w_cls.is_zero   = (i_char_code == CH_ZERO);
        w_cls.is_b      = (i_char_code == CH_LOWER_B);
        w_cls.is_x      = (i_char_code == CH_LOWER_X);
        w_cls.last      = i_last_char;
    end

    assign o_q.empty = (r_count == '0);
    assign o_q.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_stall   = o_q.full;
    assign w_push    = i_valid && !o_q.full;
    assign o_head    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + QCNT_W'(w_push) - QCNT_W'(i_pop);
        end
    end

endmodule

>>> hw/rtl/rpip_back.sv
// ----------------------------------------------------------------------------
// rpip_back
// Token engine: prefix tracking, digit accumulation and result register.
// ----------------------------------------------------------------------------
module rpip_back
    import rpip_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_char_class       i_head,
    input  t_q_stat           i_q,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [OUT_W-1:0]  o_parsed_value,
    output logic [1:0]        o_status
);

    logic [VALUE_WIDTH-1:0] r_acc, n_acc;
    t_radix                 r_radix, n_radix;
    t_phase                 r_phase, n_phase;
    logic                   r_neg, n_neg;
    t_status                r_err, n_err;
    logic                   r_body, n_body;

    logic                   r_out_valid;
    logic [VALUE_WIDTH-1:0] r_out_acc;
    logic                   r_out_neg;
    t_status                r_out_status;

    t_radix                 w_rad;
    logic                   w_do_body;
    logic                   w_in_radix;
    logic                   w_can_emit;
    logic [VALUE_WIDTH-1:0] w_scaled;
    logic [VALUE_WIDTH-1:0] w_mag;
    t_status                w_status;

    assign w_can_emit = !r_out_valid || !i_stall;
    assign o_pop      = !i_q.empty && (!i_head.last || w_can_emit);

    always_comb begin
        n_phase   = r_phase;
        n_radix   = r_radix;
        n_neg     = r_neg;
        w_do_body = 1'b0;
        w_rad     = r_radix;
        case (r_phase)
            PH_START: begin
                if (i_head.is_minus) begin
                    n_neg   = 1'b1;
                    n_phase = PH_MINUS;
                end else if (i_head.is_zero) begin
                    n_phase = PH_ZERO;
                end else begin
                    w_rad     = RADIX_DEC;
                    n_phase   = PH_BODY;
                    w_do_body = 1'b1;
                end
            end
            PH_MINUS: begin
                if (i_head.is_zero) begin
                    n_phase = PH_ZERO;
                end else begin
                    w_rad     = RADIX_DEC;
                    n_phase   = PH_BODY;
                    w_do_body = 1'b1;
                end
            end
            PH_ZERO: begin
                n_phase = PH_BODY;
                if (i_head.is_b) begin
                    w_rad = RADIX_BIN;
                end else if (i_head.is_x) begin
                    w_rad = RADIX_HEX;
                end else if (i_head.is_period) begin
                    w_rad     = RADIX_DEC;
                    w_do_body = 1'b1;
                end else begin
                    w_rad     = RADIX_OCT;
                    w_do_body = 1'b1;
                end
            end
            default: begin
                w_do_body = 1'b1;
            end
        endcase
        if (r_phase != PH_BODY) begin
            n_radix = w_rad;
        end

        case (w_rad)
            RADIX_BIN: begin
                w_in_radix = (i_head.digit < 4'd2);
                w_scaled   = r_acc << 1;
            end
            RADIX_OCT: begin
                w_in_radix = (i_head.digit < 4'd8);
                w_scaled   = r_acc << 3;
            end
            RADIX_HEX: begin
                w_in_radix = 1'b1;
                w_scaled   = r_acc << 4;
            end
            default: begin
                w_in_radix = (i_head.digit < 4'd10);
                w_scaled   = (r_acc << 3) + (r_acc << 1);
            end
        endcase

        n_acc  = r_acc;
        n_err  = r_err;
        n_body = r_body;
        if (w_do_body) begin
            n_body = 1'b1;
            if (i_head.is_period) begin
                n_err = ST_FRACTION;
            end else if (r_err != ST_OK) begin
                n_err = r_err;
            end else if (i_head.is_minus) begin
                if (r_acc == '0) begin
                    n_neg = 1'b1;
                end else begin
                    n_err = ST_INVALID;
                end
            end else if (!i_head.is_digit || !w_in_radix) begin
                n_err = ST_INVALID;
            end else begin
                n_acc = w_scaled + VALUE_WIDTH'(i_head.digit);
            end
        end
        // a token ending on its leading zero is a plain zero
        if (i_head.last && (n_phase == PH_ZERO)) begin
            n_body = 1'b1;
        end

        if (n_err != ST_OK) begin
            w_status = n_err;
        end else if (!n_body) begin
            w_status = ST_EMPTY;
        end else begin
            w_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_radix <= RADIX_DEC;
            r_phase <= PH_START;
            r_neg   <= 1'b0;
            r_err   <= ST_OK;
            r_body  <= 1'b0;
        end else if (o_pop) begin
            if (i_head.last) begin
                r_acc   <= '0;
                r_radix <= RADIX_DEC;
                r_phase <= PH_START;
                r_neg   <= 1'b0;
                r_err   <= ST_OK;
                r_body  <= 1'b0;
            end else begin
                r_acc   <= n_acc;
                r_radix <= n_radix;
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_err   <= n_err;
                r_body  <= n_body;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_head.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.last) begin
            r_out_status <= w_status;
            r_out_neg    <= n_neg;
            r_out_acc    <= (w_status == ST_OK) ? n_acc : '0;
        end
    end

    // final negate after the result register
    assign w_mag          = r_out_neg ? (~r_out_acc + 1'b1) : r_out_acc;
    assign o_valid        = r_out_valid;
    assign o_parsed_value = OUT_W'(w_mag);
    assign o_status       = r_out_status;

endmodule

>>> hw/rtl/radix_prefixed_integer_parser.sv
// ----------------------------------------------------------------------------
// radix_prefixed_integer_parser
// Parses a character stream of numeric tokens with radix prefix into values.
// ----------------------------------------------------------------------------
//  channel | valid   | stall   | payload
//  input   | i_valid | o_stall | i_char_code, i_last_char
//  output  | o_valid | i_stall | o_parsed_value, o_status
//
//  One character per cycle while o_stall is low; the accumulator shift-add in rpip_back sets it.
//  An accepted last character passes the queue and then the result register to o_valid.
//  Two-entry queue between classifier and token engine; a stalled output
//  holds the engine only on a last character.
//  Synchronous active-low reset clears queue, token state and output valid.
module radix_prefixed_integer_parser
    import rpip_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_char_code,
    input  logic              i_last_char,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [OUT_W-1:0]  o_parsed_value,
    output logic [1:0]        o_status
);

    t_char_class w_head;
    t_q_stat     w_q;
    logic        w_pop;

    rpip_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .o_head      (w_head),
        .o_q         (w_q),
        .i_pop       (w_pop)
    );

    rpip_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .i_q            (w_q),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_parsed_value (o_parsed_value),
        .o_status       (o_status)
    );

    a_q_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q.full && w_q.empty))
        else $error("queue full and empty together");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q.empty)
        else $error("pop from empty queue");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> (o_parsed_value == '0))
        else $error("nonzero value with error status");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop && w_head.last |=> o_valid)
        else $error("last character did not produce a transaction");

endmodule
